### sv/dbom_pkg.sv
`default_nettype none

package dbom_pkg;

   // Field widths of the sample and result channels.
   localparam int TEMP_W     = 16;
   localparam int COMB_W     = 20;
   localparam int TIMER_W    = 17;
   localparam int TICKS_W    = 16;
   localparam int REQ_W      = 32;
   localparam int RSP_W      = 56;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Default averaging window length.
   localparam int AVG_SAMPLES_DEFAULT = 10;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_CTRL_WARN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CTRL_ALARM = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CTRL_CLEAR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PWR_WARN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PWR_ALARM = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PWR_CLEAR = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DETECT_TICKS = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_STARTUP_TICKS = 3'd7;

   // Register reset values.
   localparam logic [TEMP_W-1:0] WARN_TEMP_RESET = 16'd850;
   localparam logic [TEMP_W-1:0] ALARM_TEMP_RESET = 16'd950;
   localparam logic [TEMP_W-1:0] CLEAR_TEMP_RESET = 16'd800;
   localparam logic [TICKS_W-1:0] DETECT_TICKS_RESET = 16'd10000;
   localparam logic [TICKS_W-1:0] STARTUP_TICKS_RESET = 16'd1000;

   // Thresholds of one board, all signed 0.1 degree values.
   typedef struct packed {
      logic [TEMP_W-1:0] warn;
      logic [TEMP_W-1:0] alarm;
      logic [TEMP_W-1:0] clear;
   } dbom_limits_type;

   // Status flags of one board.
   typedef struct packed {
      logic warning;
      logic alarm;
   } dbom_flags_type;

   // Board mode, one-hot.
   typedef enum logic [2:0] {
      MODE_NORMAL = 3'b001,
      MODE_WARN   = 3'b010,
      MODE_ALARM  = 3'b100
   } dbom_mode_type;

endpackage

`default_nettype wire

### sv/dbom_lane.sv
`default_nettype none

module dbom_lane (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire logic                   startup_done,
   input  wire logic [15:0]            temp,
   input  wire dbom_pkg::dbom_limits_type limits,
   input  wire logic [15:0]            detect_ticks,
   output dbom_pkg::dbom_flags_type    flags
);
   import dbom_pkg::*;

   dbom_mode_type         mode_ff, mode_in;
   logic [TIMER_W-1:0]    warn_timer_ff, warn_timer_in;
   logic [TIMER_W-1:0]    alarm_timer_ff, alarm_timer_in;
   dbom_flags_type        flags_ff, flags_in;
   logic                  warn_over, alarm_over;
   logic                  above_warn, below_warn, above_alarm, above_clear;

   // Threshold and timer comparisons.
   assign above_warn  = $signed(temp) > $signed(limits.warn);
   assign below_warn  = $signed(temp) < $signed(limits.warn);
   assign above_alarm = $signed(temp) > $signed(limits.alarm);
   assign above_clear = $signed(temp) > $signed(limits.clear);
   assign warn_over   = warn_timer_ff > {1'b0, detect_ticks};
   assign alarm_over  = alarm_timer_ff > {1'b0, detect_ticks};

   // Board state machine, advanced once for every accepted sample.
   always_comb begin
      mode_in        = mode_ff;
      warn_timer_in  = warn_timer_ff;
      alarm_timer_in = alarm_timer_ff;
      flags_in       = flags_ff;
      if (fire) begin
         if (!startup_done) begin
            // Start-up window: only a persistence check on the clear level.
            if (above_clear) begin
               if (alarm_over) begin
                  mode_in          = MODE_ALARM;
                  flags_in.warning = 1'b0;
                  flags_in.alarm   = 1'b1;
               end else begin
                  alarm_timer_in = alarm_timer_ff + TIMER_W'(1);
               end
            end else begin
               alarm_timer_in = '0;
            end
         end else begin
            unique case (mode_ff)
               MODE_WARN: begin
                  if (above_alarm) begin
                     if (alarm_over) begin
                        mode_in          = MODE_ALARM;
                        flags_in.warning = 1'b0;
                        flags_in.alarm   = 1'b1;
                     end else begin
                        alarm_timer_in = alarm_timer_ff + TIMER_W'(1);
                     end
                  end else if (below_warn) begin
                     mode_in          = MODE_NORMAL;
                     flags_in.warning = 1'b0;
                  end else begin
                     flags_in.warning = 1'b1;
                     alarm_timer_in   = '0;
                  end
               end
               MODE_ALARM: begin
                  if (above_clear) begin
                     flags_in.warning = 1'b0;
                     flags_in.alarm   = 1'b1;
                  end else begin
                     mode_in = MODE_NORMAL;
                  end
               end
               default: begin
                  // Normal mode; a corrupted code is treated the same way.
                  mode_in = MODE_NORMAL;
                  if (above_warn) begin
                     if (warn_over) begin
                        mode_in          = MODE_WARN;
                        flags_in.warning = 1'b1;
                     end else begin
                        warn_timer_in = warn_timer_ff + TIMER_W'(1);
                     end
                  end else begin
                     warn_timer_in = '0;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_NORMAL;
         warn_timer_ff  <= '0;
         alarm_timer_ff <= '0;
         flags_ff       <= '0;
      end else begin
         mode_ff        <= mode_in;
         warn_timer_ff  <= warn_timer_in;
         alarm_timer_ff <= alarm_timer_in;
         flags_ff       <= flags_in;
      end
   end

   assign flags = flags_ff;

endmodule

`default_nettype wire

### sv/dbom_accum.sv
`default_nettype none

module dbom_accum #(
   parameter int AVG_SAMPLES = dbom_pkg::AVG_SAMPLES_DEFAULT,
   parameter int SUM_W       = 20
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    fire,
   input  wire logic                    advance,
   input  wire logic [15:0]             ctrl_temp,
   input  wire logic [15:0]             pwr_temp,
   output logic                         update,
   output logic signed [SUM_W-1:0]      ctrl_total,
   output logic signed [SUM_W-1:0]      pwr_total
);
   import dbom_pkg::*;

   localparam int CNT_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] ctrl_sum_ff, ctrl_sum_in;
   logic signed [SUM_W-1:0] pwr_sum_ff, pwr_sum_in;
   logic signed [SUM_W-1:0] ctrl_next, pwr_next;
   logic                    update_ff;
   logic signed [SUM_W-1:0] ctrl_total_ff, pwr_total_ff;
   logic                    wrap;

   // Running sums including the current sample.
   assign ctrl_next = ctrl_sum_ff + SUM_W'($signed(ctrl_temp));
   assign pwr_next  = pwr_sum_ff + SUM_W'($signed(pwr_temp));
   assign wrap      = count_ff == CNT_W'(AVG_SAMPLES - 1);

   // Window bookkeeping: the last sample of a window clears the sums.
   always_comb begin
      count_in    = count_ff;
      ctrl_sum_in = ctrl_sum_ff;
      pwr_sum_in  = pwr_sum_ff;
      if (fire) begin
         if (wrap) begin
            count_in    = '0;
            ctrl_sum_in = '0;
            pwr_sum_in  = '0;
         end else begin
            count_in    = count_ff + CNT_W'(1);
            ctrl_sum_in = ctrl_next;
            pwr_sum_in  = pwr_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         ctrl_sum_ff <= '0;
         pwr_sum_ff  <= '0;
         update_ff   <= 1'b0;
      end else begin
         count_ff    <= count_in;
         ctrl_sum_ff <= ctrl_sum_in;
         pwr_sum_ff  <= pwr_sum_in;
         if (advance) begin
            update_ff <= fire && wrap;
         end
      end
   end

   // Completed window totals handed to the dividers.
   always_ff @(posedge clock) begin
      if (fire && wrap) begin
         ctrl_total_ff <= ctrl_next;
         pwr_total_ff  <= pwr_next;
      end
   end

   assign update     = update_ff;
   assign ctrl_total = ctrl_total_ff;
   assign pwr_total  = pwr_total_ff;

endmodule

`default_nettype wire

### sv/dbom_div.sv
`default_nettype none

module dbom_div #(
   parameter int AVG_SAMPLES = dbom_pkg::AVG_SAMPLES_DEFAULT,
   parameter int SUM_W       = 20,
   parameter int OUT_W       = 16
) (
   input  wire logic                    clock,
   input  wire logic                    advance,
   input  wire logic signed [SUM_W-1:0] dividend,
   output logic signed [OUT_W-1:0]      quotient
);
   import dbom_pkg::*;

   // Round-up reciprocal; exact for every magnitude below 2**SUM_W.
   localparam int SHIFT   = SUM_W + $clog2(AVG_SAMPLES);
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((longint'(1) << SHIFT) + longint'(AVG_SAMPLES) - 1) / AVG_SAMPLES);

   logic [SUM_W-1:0]      mag;
   logic                  neg_ff;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [PROD_W-1:0]     shifted;
   logic [SUM_W-1:0]      q_mag;
   logic signed [SUM_W:0] q_signed;

   // Sign and magnitude, then multiply by the reciprocal.
   assign mag     = dividend[SUM_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
   assign prod_in = PROD_W'(mag) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (advance) begin
         neg_ff  <= dividend[SUM_W-1];
         prod_ff <= prod_in;
      end
   end

   // Drop the fraction and restore the sign: truncation toward zero.
   assign shifted  = prod_ff >> SHIFT;
   assign q_mag    = shifted[SUM_W-1:0];
   assign q_signed = neg_ff ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
   assign quotient = OUT_W'(q_signed);

endmodule

`default_nettype wire

### sv/dual_board_overheat_monitor.sv
// Overheat monitor for a control board and a power board.
// The req channel carries one scan tick per transfer: both board temperatures
// in signed 0.1 degree units. Every transfer yields exactly one rsp transfer
// with the warning and latched alarm flags of both boards and the held
// ten-sample monitor values (two board averages and the combined half sum).
// rsp_tuser is high on the tick that refreshed the monitor values.
// Pipeline: three register stages from req to rsp. Throughput: one sample per
// cycle while rsp is not stalled, set by the board state machines; the
// reciprocal multiply of each average lane takes one pipeline stage of
// its own.
// If the receiver holds rsp_tready low while rsp_tvalid is high, all stages
// freeze and req_tready drops in the same cycle; no result is lost.
// Thresholds and timer limits are written through the csr port; the user must
// write them only while idle, which the block does not enforce. Synchronous
// reset restores the register defaults, clears sums, timers, flags and held
// monitors, restarts the start-up window and empties the pipeline.
`default_nettype none

module dual_board_overheat_monitor #(
   parameter int AVG_SAMPLES = dbom_pkg::AVG_SAMPLES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Fields from bit 0: ctrl_temp[15:0], pwr_temp[31:16].
   input  wire logic [dbom_pkg::REQ_W-1:0]        req_tdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // Fields from bit 0: ctrl_warning, ctrl_alarm, pwr_warning, pwr_alarm,
   // combined_temp[23:4], ctrl_average[39:24], pwr_average[55:40].
   output logic [dbom_pkg::RSP_W-1:0]             rsp_tdata,
   // Fields from bit 0: monitor_updated.
   output logic                                   rsp_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_we,
   input  wire logic [dbom_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dbom_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dbom_pkg::*;

   localparam int SUM_W = TEMP_W + $clog2(AVG_SAMPLES);

   dbom_limits_type       ctrl_limits_ff, pwr_limits_ff;
   logic [TICKS_W-1:0]    detect_ticks_ff, startup_ticks_ff;
   logic                  startup_done_ff, startup_done_in;
   logic [TIMER_W-1:0]    startup_timer_ff, startup_timer_in;
   logic                  advance, fire;
   logic                  v1_ff, v2_ff, rsp_tvalid_ff;
   dbom_flags_type        ctrl_flags, pwr_flags;
   dbom_flags_type        ctrl_flags2_ff, pwr_flags2_ff;
   dbom_flags_type        ctrl_flags3_ff, pwr_flags3_ff;
   logic                  update1;
   logic                  update2_ff, update3_ff;
   logic signed [SUM_W-1:0] ctrl_total, pwr_total;
   logic signed [SUM_W:0]   grand_total;
   logic signed [SUM_W:0]   half_total;
   logic signed [COMB_W-1:0] combined2_ff;
   logic signed [TEMP_W-1:0] ctrl_quot, pwr_quot;
   logic signed [COMB_W-1:0] combined_ff;
   logic signed [TEMP_W-1:0] ctrl_avg_ff, pwr_avg_ff;

   // Whole pipeline moves unless a result waits on a stalled receiver.
   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = advance;
   assign fire       = req_tvalid && advance;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_limits_ff   <= '{WARN_TEMP_RESET, ALARM_TEMP_RESET, CLEAR_TEMP_RESET};
         pwr_limits_ff    <= '{WARN_TEMP_RESET, ALARM_TEMP_RESET, CLEAR_TEMP_RESET};
         detect_ticks_ff  <= DETECT_TICKS_RESET;
         startup_ticks_ff <= STARTUP_TICKS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_CTRL_WARN:     ctrl_limits_ff.warn  <= csr_wdata;
            REG_CTRL_ALARM:    ctrl_limits_ff.alarm <= csr_wdata;
            REG_CTRL_CLEAR:    ctrl_limits_ff.clear <= csr_wdata;
            REG_PWR_WARN:      pwr_limits_ff.warn   <= csr_wdata;
            REG_PWR_ALARM:     pwr_limits_ff.alarm  <= csr_wdata;
            REG_PWR_CLEAR:     pwr_limits_ff.clear  <= csr_wdata;
            REG_DETECT_TICKS:  detect_ticks_ff      <= csr_wdata;
            REG_STARTUP_TICKS: startup_ticks_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Start-up window timer, shared by both boards.
   always_comb begin
      startup_timer_in = startup_timer_ff;
      startup_done_in  = startup_done_ff;
      if (fire && !startup_done_ff) begin
         startup_timer_in = startup_timer_ff + TIMER_W'(1);
         startup_done_in  = startup_timer_in > {1'b0, startup_ticks_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         startup_timer_ff <= '0;
         startup_done_ff  <= 1'b0;
      end else begin
         startup_timer_ff <= startup_timer_in;
         startup_done_ff  <= startup_done_in;
      end
   end

   // Board lanes.
   dbom_lane u_ctrl_lane (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .startup_done (startup_done_ff),
      .temp         (req_tdata[15:0]),
      .limits       (ctrl_limits_ff),
      .detect_ticks (detect_ticks_ff),
      .flags        (ctrl_flags)
   );

   dbom_lane u_pwr_lane (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .startup_done (startup_done_ff),
      .temp         (req_tdata[31:16]),
      .limits       (pwr_limits_ff),
      .detect_ticks (detect_ticks_ff),
      .flags        (pwr_flags)
   );

   // Window sums.
   dbom_accum #(
      .AVG_SAMPLES (AVG_SAMPLES),
      .SUM_W       (SUM_W)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .advance    (advance),
      .ctrl_temp  (req_tdata[15:0]),
      .pwr_temp   (req_tdata[31:16]),
      .update     (update1),
      .ctrl_total (ctrl_total),
      .pwr_total  (pwr_total)
   );

   // Average lanes.
   dbom_div #(
      .AVG_SAMPLES (AVG_SAMPLES),
      .SUM_W       (SUM_W),
      .OUT_W       (TEMP_W)
   ) u_ctrl_div (
      .clock    (clock),
      .advance  (advance),
      .dividend (ctrl_total),
      .quotient (ctrl_quot)
   );

   dbom_div #(
      .AVG_SAMPLES (AVG_SAMPLES),
      .SUM_W       (SUM_W),
      .OUT_W       (TEMP_W)
   ) u_pwr_div (
      .clock    (clock),
      .advance  (advance),
      .dividend (pwr_total),
      .quotient (pwr_quot)
   );

   // Combined half sum rounds toward minus infinity.
   assign grand_total = (SUM_W+1)'(ctrl_total) + (SUM_W+1)'(pwr_total);
   assign half_total  = grand_total >>> 1;

   // Pipeline valid bits and flag stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         update2_ff    <= 1'b0;
         update3_ff    <= 1'b0;
      end else if (advance) begin
         v1_ff         <= fire;
         v2_ff         <= v1_ff;
         rsp_tvalid_ff <= v2_ff;
         update2_ff    <= v1_ff && update1;
         update3_ff    <= v2_ff && update2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctrl_flags2_ff <= ctrl_flags;
         pwr_flags2_ff  <= pwr_flags;
         combined2_ff   <= COMB_W'(half_total);
         ctrl_flags3_ff <= ctrl_flags2_ff;
         pwr_flags3_ff  <= pwr_flags2_ff;
      end
   end

   // Merge stage: held monitor values refresh on a window end.
   always_ff @(posedge clock) begin
      if (reset) begin
         combined_ff <= '0;
         ctrl_avg_ff <= '0;
         pwr_avg_ff  <= '0;
      end else if (advance && v2_ff && update2_ff) begin
         combined_ff <= combined2_ff;
         ctrl_avg_ff <= ctrl_quot;
         pwr_avg_ff  <= pwr_quot;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = update3_ff;
   assign rsp_tdata  = {pwr_avg_ff, ctrl_avg_ff, combined_ff,
                        pwr_flags3_ff.alarm, pwr_flags3_ff.warning,
                        ctrl_flags3_ff.alarm, ctrl_flags3_ff.warning};

   // The start-up window closes once and stays closed.
   a_startup_sticky: assert property (@(posedge clock) disable iff (reset)
      startup_done_ff |=> startup_done_ff)
      else $error("start-up window reopened");

   // Alarm flags latch until reset.
   a_ctrl_alarm_latch: assert property (@(posedge clock) disable iff (reset)
      ctrl_flags.alarm |=> ctrl_flags.alarm)
      else $error("control board alarm cleared");

   a_pwr_alarm_latch: assert property (@(posedge clock) disable iff (reset)
      pwr_flags.alarm |=> pwr_flags.alarm)
      else $error("power board alarm cleared");

   // A stalled pipeline keeps its inner items.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !advance) |=> (v1_ff && $stable(ctrl_flags2_ff)))
      else $error("item lost in stalled pipeline");

endmodule

`default_nettype wire

### tb/dual_board_overheat_monitor_test.sv
`timescale 1ns / 1ps

module dual_board_overheat_monitor_test;
   import dbom_pkg::*;

   localparam int CTRL_SIDE   = 0;
   localparam int PWR_SIDE    = 1;
   localparam int AVG_LEN     = AVG_SAMPLES_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [TEMP_W-1:0] TEMP_MIN = 16'h8000;
   localparam logic [TEMP_W-1:0] TEMP_MAX = 16'h7FFF;
   // Floor of half the total when a window holds ten maximum and ten minimum samples.
   localparam logic [COMB_W-1:0] COMB_SPLIT = 20'hFFFFB;

   // One result transfer, field by field.
   typedef struct packed {
      logic                ctrl_warning;
      logic                ctrl_alarm;
      logic                pwr_warning;
      logic                pwr_alarm;
      logic                updated;
      logic [COMB_W-1:0]   combined;
      logic [TEMP_W-1:0]   ctrl_avg;
      logic [TEMP_W-1:0]   pwr_avg;
   } board_status_type;

   // One row of the directed stimulus table.
   typedef struct packed {
      logic [TEMP_W-1:0] ctrl;
      logic [TEMP_W-1:0] pwr;
      logic              typed;
      board_status_type  want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor copy of the configuration.
   logic signed [TEMP_W-1:0] warn_lvl [2];
   logic signed [TEMP_W-1:0] alarm_lvl [2];
   logic signed [TEMP_W-1:0] clear_lvl [2];
   int unsigned              detect_lim;
   int unsigned              startup_lim;

   // Predictor copy of the block state.
   int                  ctrl_acc;
   int                  pwr_acc;
   int unsigned         sample_cnt;
   bit                  startup_done;
   int unsigned         startup_timer;
   dbom_mode_type       board_mode [2];
   int unsigned         warn_tmr [2];
   int unsigned         alarm_tmr [2];
   logic                warn_flag [2];
   logic                alarm_flag [2];
   logic [COMB_W-1:0]   held_comb;
   logic [TEMP_W-1:0]   held_cavg;
   logic [TEMP_W-1:0]   held_pavg;

   board_status_type    status_pending [$];
   board_status_type    status_head;
   stim_row_type        steer_rows [$];
   logic [TEMP_W-1:0]   phase_regs [8];
   logic [TEMP_W-1:0]   level [2];
   int                  hold_left [2];
   bit                  req_quiet = 1'b1;
   bit                  rsp_quiet = 1'b1;
   int                  fail_count = 0;
   int                  cycle_count = 0;

   dual_board_overheat_monitor u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Free-running clock, 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Restore the register defaults and clear the predicted state.
   function automatic void clear_monitor();
      int b;
      for (b = 0; b < 2; b++) begin
         warn_lvl[b]   = WARN_TEMP_RESET;
         alarm_lvl[b]  = ALARM_TEMP_RESET;
         clear_lvl[b]  = CLEAR_TEMP_RESET;
         board_mode[b] = MODE_NORMAL;
         warn_tmr[b]   = 0;
         alarm_tmr[b]  = 0;
         warn_flag[b]  = 1'b0;
         alarm_flag[b] = 1'b0;
         hold_left[b]  = 0;
         level[b]      = '0;
      end
      detect_lim    = DETECT_TICKS_RESET;
      startup_lim   = STARTUP_TICKS_RESET;
      ctrl_acc      = 0;
      pwr_acc       = 0;
      sample_cnt    = 0;
      startup_done  = 1'b0;
      startup_timer = 0;
      held_comb     = '0;
      held_cavg     = '0;
      held_pavg     = '0;
   endfunction

   // Mirror one register write into the predictor.
   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [TEMP_W-1:0] val);
      case (idx)
         REG_CTRL_WARN:     warn_lvl[CTRL_SIDE] = val;
         REG_CTRL_ALARM:    alarm_lvl[CTRL_SIDE] = val;
         REG_CTRL_CLEAR:    clear_lvl[CTRL_SIDE] = val;
         REG_PWR_WARN:      warn_lvl[PWR_SIDE] = val;
         REG_PWR_ALARM:     alarm_lvl[PWR_SIDE] = val;
         REG_PWR_CLEAR:     clear_lvl[PWR_SIDE] = val;
         REG_DETECT_TICKS:  detect_lim = val;
         REG_STARTUP_TICKS: startup_lim = val;
         default: ;
      endcase
   endfunction

   // Overheat state machine of one board for one sample.
   function automatic void step_board(int b, logic signed [TEMP_W-1:0] t);
      if (!startup_done) begin
         // Start-up window: only the persistence check against the clear level.
         if (t > clear_lvl[b]) begin
            if (alarm_tmr[b] > detect_lim) begin
               board_mode[b] = MODE_ALARM;
               warn_flag[b]  = 1'b0;
               alarm_flag[b] = 1'b1;
            end else begin
               alarm_tmr[b]++;
            end
         end else begin
            alarm_tmr[b] = 0;
         end
      end else begin
         case (board_mode[b])
            MODE_WARN: begin
               if (t > alarm_lvl[b]) begin
                  if (alarm_tmr[b] > detect_lim) begin
                     warn_flag[b]  = 1'b0;
                     alarm_flag[b] = 1'b1;
                     board_mode[b] = MODE_ALARM;
                  end else begin
                     alarm_tmr[b]++;
                  end
               end else if (t < warn_lvl[b]) begin
                  warn_flag[b]  = 1'b0;
                  board_mode[b] = MODE_NORMAL;
               end else begin
                  warn_flag[b] = 1'b1;
                  alarm_tmr[b] = 0;
               end
            end
            MODE_ALARM: begin
               // The alarm is raised again while above the clear level.
               if (t > clear_lvl[b]) begin
                  warn_flag[b]  = 1'b0;
                  alarm_flag[b] = 1'b1;
               end else begin
                  board_mode[b] = MODE_NORMAL;
               end
            end
            default: begin
               board_mode[b] = MODE_NORMAL;
               if (t > warn_lvl[b]) begin
                  if (warn_tmr[b] > detect_lim) begin
                     warn_flag[b]  = 1'b1;
                     board_mode[b] = MODE_WARN;
                  end else begin
                     warn_tmr[b]++;
                  end
               end else begin
                  warn_tmr[b] = 0;
               end
            end
         endcase
      end
   endfunction

   // Advance the monitor by one scan tick and return the status it reports.
   function automatic board_status_type advance_monitor(logic signed [TEMP_W-1:0] ct,
                                                        logic signed [TEMP_W-1:0] pt);
      board_status_type r;
      int               tot;
      r = '0;
      // Averaging window.
      ctrl_acc += int'(ct);
      pwr_acc  += int'(pt);
      sample_cnt++;
      if (sample_cnt >= AVG_LEN) begin
         tot        = ctrl_acc + pwr_acc;
         held_comb  = COMB_W'(tot >>> 1);
         held_cavg  = TEMP_W'(ctrl_acc / AVG_LEN);
         held_pavg  = TEMP_W'(pwr_acc / AVG_LEN);
         ctrl_acc   = 0;
         pwr_acc    = 0;
         sample_cnt = 0;
         r.updated  = 1'b1;
      end
      step_board(CTRL_SIDE, ct);
      step_board(PWR_SIDE, pt);
      if (!startup_done) begin
         startup_timer++;
         if (startup_timer > startup_lim)
            startup_done = 1'b1;
      end
      r.ctrl_warning = warn_flag[CTRL_SIDE];
      r.ctrl_alarm   = alarm_flag[CTRL_SIDE];
      r.pwr_warning  = warn_flag[PWR_SIDE];
      r.pwr_alarm    = alarm_flag[PWR_SIDE];
      r.combined     = held_comb;
      r.ctrl_avg     = held_cavg;
      r.pwr_avg      = held_pavg;
      return r;
   endfunction

   // Next sample of one board: levels near its thresholds, held for a while,
   // with some full-range noise.
   function automatic logic [TEMP_W-1:0] next_temp(int b);
      int pick;
      if (hold_left[b] == 0) begin
         hold_left[b] = $urandom_range(1, 12);
         pick = $urandom_range(0, 99);
         if (pick < 8)
            level[b] = TEMP_W'($urandom);
         else if (pick < 38)
            level[b] = warn_lvl[b] + TEMP_W'($urandom_range(0, 6)) - 16'd3;
         else if (pick < 68)
            level[b] = alarm_lvl[b] + TEMP_W'($urandom_range(0, 6)) - 16'd3;
         else
            level[b] = clear_lvl[b] + TEMP_W'($urandom_range(0, 6)) - 16'd3;
      end
      hold_left[b]--;
      return level[b];
   endfunction

   // Write all eight registers while the block is idle.
   task automatic program_limits(input logic [TEMP_W-1:0] cw, ca, cc, pw, pa, pc, det, stp);
      int i;
      phase_regs[REG_CTRL_WARN]     = cw;
      phase_regs[REG_CTRL_ALARM]    = ca;
      phase_regs[REG_CTRL_CLEAR]    = cc;
      phase_regs[REG_PWR_WARN]      = pw;
      phase_regs[REG_PWR_ALARM]     = pa;
      phase_regs[REG_PWR_CLEAR]     = pc;
      phase_regs[REG_DETECT_TICKS]  = det;
      phase_regs[REG_STARTUP_TICKS] = stp;
      for (i = 0; i <= int'(REG_STARTUP_TICKS); i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= phase_regs[i];
         @(posedge clock);
         apply_reg(CSR_IDX_W'(i), phase_regs[i]);
      end
      csr_we <= 1'b0;
   endtask

   // One sample transfer; the expected status is queued at acceptance.
   task automatic send_sample(input logic [TEMP_W-1:0] ct, pt, input logic typed,
                              input board_status_type want);
      int               gap;
      board_status_type pred;
      gap = req_quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pt, ct};
      do @(posedge clock); while (!req_tready);
      pred = advance_monitor(ct, pt);
      status_pending.push_back(typed ? want : pred);
   endtask

   // Hold off the sender until every queued status has been seen.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (status_pending.size() != 0) @(posedge clock);
   endtask

   // One phase of random samples under the current limits.
   task automatic run_phase(input int count);
      int n;
      req_quiet = ($urandom_range(0, 3) == 0);
      rsp_quiet = ($urandom_range(0, 3) == 0);
      for (n = 0; n < count; n++)
         send_sample(next_temp(CTRL_SIDE), next_temp(PWR_SIDE), 1'b0, '0);
      drain();
   endtask

   task automatic check_field(input string name, input logic [COMB_W-1:0] want, got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", name, want, got);
         fail_count++;
      end
   endtask

   // Receiver pacing: a random stall before each transfer.
   initial begin : rsp_pace
      int stall;
      forever begin
         stall = rsp_quiet ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && !reset));
      end
   end

   // Compare every result transfer with the oldest queued status.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (status_pending.size() == 0) begin
            $error("result transfer with no status pending");
            fail_count++;
         end else begin
            status_head = status_pending.pop_front();
            check_field("ctrl_warning", COMB_W'(status_head.ctrl_warning), COMB_W'(rsp_tdata[0]));
            check_field("ctrl_alarm", COMB_W'(status_head.ctrl_alarm), COMB_W'(rsp_tdata[1]));
            check_field("pwr_warning", COMB_W'(status_head.pwr_warning), COMB_W'(rsp_tdata[2]));
            check_field("pwr_alarm", COMB_W'(status_head.pwr_alarm), COMB_W'(rsp_tdata[3]));
            check_field("monitor_updated", COMB_W'(status_head.updated), COMB_W'(rsp_tuser));
            check_field("combined_temp", status_head.combined, rsp_tdata[23:4]);
            check_field("ctrl_average", COMB_W'(status_head.ctrl_avg), COMB_W'(rsp_tdata[39:24]));
            check_field("pwr_average", COMB_W'(status_head.pwr_avg), COMB_W'(rsp_tdata[55:40]));
         end
      end
   end

   // Main sequence: reset, directed table, random phases, verdict.
   initial begin : main_seq
      stim_row_type row;
      int           i;
      clear_monitor();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Two full windows of opposite extremes under the reset limits: the
      // flags stay low because no timer gets near the detect time.
      for (i = 0; i < 20; i++) begin
         row.ctrl  = (i < 10) ? TEMP_MAX : TEMP_MIN;
         row.pwr   = (i < 10) ? TEMP_MIN : TEMP_MAX;
         row.typed = 1'b1;
         row.want  = '0;
         row.want.updated = (i == 9) || (i == 19);
         if (i >= 9) begin
            row.want.combined = COMB_SPLIT;
            row.want.ctrl_avg = (i < 19) ? TEMP_MAX : TEMP_MIN;
            row.want.pwr_avg  = (i < 19) ? TEMP_MIN : TEMP_MAX;
         end
         steer_rows.push_back(row);
      end
      // Values around the thresholds and mixed bit patterns.
      row = '0;
      row.ctrl = 16'd801;  row.pwr = 16'd800;  steer_rows.push_back(row);
      row.ctrl = 16'h5555; row.pwr = 16'hAAAA; steer_rows.push_back(row);
      row.ctrl = 16'hFFFF; row.pwr = 16'd0;    steer_rows.push_back(row);
      row.ctrl = 16'd850;  row.pwr = 16'd951;  steer_rows.push_back(row);
      row.ctrl = 16'd0;    row.pwr = 16'hFFFF; steer_rows.push_back(row);

      req_quiet = 1'b1;
      rsp_quiet = 1'b0;
      foreach (steer_rows[k])
         send_sample(steer_rows[k].ctrl, steer_rows[k].pwr, steer_rows[k].typed,
                     steer_rows[k].want);
      drain();

      // Long start-up window: the control board can raise a start-up alarm,
      // the power board cannot since nothing exceeds its clear level.
      program_limits(16'd850, 16'd950, 16'd800, 16'd850, 16'd950, TEMP_MAX,
                     16'd3, TEMP_MAX);
      run_phase(150);

      // End the start-up window and use ordered thresholds with a short timer.
      program_limits(16'd300, 16'd500, 16'd200, 16'd300, 16'd500, 16'd200,
                     16'd2, 16'd0);
      run_phase(250);

      // Extreme thresholds, out of order, with a detect time of zero.
      program_limits(TEMP_MIN, TEMP_MAX, TEMP_MIN, TEMP_MAX, TEMP_MIN, 16'd0,
                     16'd0, 16'd1000);
      run_phase(200);

      // Reversed and coinciding thresholds.
      program_limits(16'd600, 16'd400, 16'd700, 16'd100, 16'd100, 16'd100,
                     16'd5, 16'd0);
      run_phase(250);

      // Longest detect time with random thresholds.
      program_limits(TEMP_W'($urandom_range(0, 4000) - 2000),
                     TEMP_W'($urandom_range(0, 4000) - 2000),
                     TEMP_W'($urandom_range(0, 4000) - 2000),
                     TEMP_W'($urandom_range(0, 4000) - 2000),
                     TEMP_W'($urandom_range(0, 4000) - 2000),
                     TEMP_W'($urandom_range(0, 4000) - 2000),
                     16'hFFFF, 16'd1000);
      run_phase(100);

      // Random thresholds with a one-tick detect.
      program_limits(TEMP_W'($urandom_range(0, 4000) - 2000),
                     TEMP_W'($urandom_range(0, 4000) - 2000),
                     TEMP_W'($urandom_range(0, 4000) - 2000),
                     TEMP_W'($urandom_range(0, 4000) - 2000),
                     TEMP_W'($urandom_range(0, 4000) - 2000),
                     TEMP_W'($urandom_range(0, 4000) - 2000),
                     16'd1, 16'd1000);
      run_phase(350);

      // Back to the reset thresholds.
      program_limits(WARN_TEMP_RESET, ALARM_TEMP_RESET, CLEAR_TEMP_RESET,
                     WARN_TEMP_RESET, ALARM_TEMP_RESET, CLEAR_TEMP_RESET,
                     16'd4, STARTUP_TICKS_RESET);
      run_phase(350);

      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### files.f
sv/dbom_pkg.sv
sv/dbom_lane.sv
sv/dbom_accum.sv
sv/dbom_div.sv
sv/dual_board_overheat_monitor.sv
tb/dual_board_overheat_monitor_test.sv
